// File: sv/phaf_pkg.sv
// -----------------------------------------------------------------------------
// phaf_pkg
// Shared types and constants for the packet header anomaly filter.
// -----------------------------------------------------------------------------
package phaf_pkg;

	localparam int NUM_REASONS = 14;
	localparam int QUEUE_DEPTH = 2;

	// protocol codes as delivered by the header parser
	localparam logic [1:0] PROTO_OTHER = 2'd0;
	localparam logic [1:0] PROTO_TCP   = 2'd1;
	localparam logic [1:0] PROTO_UDP   = 2'd2;
	localparam logic [1:0] PROTO_ICMP  = 2'd3;

	// TCP flag bit positions
	localparam int FLAG_FIN = 0;
	localparam int FLAG_SYN = 1;
	localparam int FLAG_RST = 2;
	localparam int FLAG_PSH = 3;
	localparam int FLAG_ACK = 4;
	localparam int FLAG_URG = 5;

	localparam logic [15:0] DNS_PORT = 16'd53;

	localparam logic [7:0] OCTET_MCAST    = 8'd224;
	localparam logic [7:0] OCTET_RESERVED = 8'd240;

	localparam logic [7:0] ICMP_ECHO_REPLY = 8'd0;
	localparam logic [7:0] ICMP_UNREACH    = 8'd3;
	localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
	localparam logic [7:0] ICMP_TIME_EXC   = 8'd11;
	localparam logic [7:0] ICMP_UNREACH_MAX_CODE   = 8'd15;
	localparam logic [7:0] ICMP_TIME_EXC_MAX_CODE  = 8'd1;

	// configuration register indexes
	localparam logic [1:0] REG_LOCAL_ADDR = 2'd0;
	localparam logic [1:0] REG_MIN_TTL    = 2'd1;
	localparam logic [1:0] REG_DNS_LIMIT  = 2'd2;

	localparam logic [31:0] RST_LOCAL_ADDR = 32'd0;
	localparam logic [7:0]  RST_MIN_TTL    = 8'd5;
	localparam logic [15:0] RST_DNS_LIMIT  = 16'd4096;

	typedef enum logic [3:0] {
		RSN_NONE     = 4'd0,
		RSN_LAND     = 4'd1,
		RSN_TTL      = 4'd2,
		RSN_BOGON    = 4'd3,
		RSN_FRAG     = 4'd4,
		RSN_ICMP     = 4'd5,
		RSN_NULL     = 4'd6,
		RSN_FIN      = 4'd7,
		RSN_XMAS     = 4'd8,
		RSN_SYNFIN   = 4'd9,
		RSN_SYNRST   = 4'd10,
		RSN_SYNFLAGS = 4'd11,
		RSN_SYNDATA  = 4'd12,
		RSN_PORT0    = 4'd13,
		RSN_DNS      = 4'd14
	} reason_t;

	typedef struct packed {
		logic [31:0] local_address;
		logic [7:0]  min_ttl;
		logic [15:0] dns_size_limit;
	} cfg_t;

	// handoff between a producer and the next part
	typedef struct packed {
		logic    valid;
		reason_t reason;
	} verdict_t;

endpackage

// File: sv/phaf_hdr_if.sv
// -----------------------------------------------------------------------------
// phaf_hdr_if
// Header channel: one parsed IPv4 header per beat, valid/ready handshake.
// -----------------------------------------------------------------------------
interface phaf_hdr_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [1:0]  protocol;
	logic [7:0]  time_to_live;
	logic        fragmented;
	logic [7:0]  icmp_kind;
	logic [7:0]  icmp_subcode;
	logic [7:0]  tcp_flag_bits;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [15:0] packet_size;
	logic [15:0] payload_length;

	modport source (
		output valid, source_address, dest_address, protocol, time_to_live,
			fragmented, icmp_kind, icmp_subcode, tcp_flag_bits, source_port,
			dest_port, packet_size, payload_length,
		input  ready
	);

	modport sink (
		input  valid, source_address, dest_address, protocol, time_to_live,
			fragmented, icmp_kind, icmp_subcode, tcp_flag_bits, source_port,
			dest_port, packet_size, payload_length,
		output ready
	);
endinterface

// File: sv/phaf_res_if.sv
// -----------------------------------------------------------------------------
// phaf_res_if
// Verdict channel: one filter verdict per beat, valid/ready handshake.
// -----------------------------------------------------------------------------
interface phaf_res_if;
	logic        valid;
	logic        ready;
	logic        blocked;
	logic [3:0]  reason;
	logic [31:0] reason_hits;

	modport source (
		output valid, blocked, reason, reason_hits,
		input  ready
	);

	modport sink (
		input  valid, blocked, reason, reason_hits,
		output ready
	);
endinterface

// File: sv/phaf_front.sv
// -----------------------------------------------------------------------------
// phaf_front
// Accepts headers and runs the priority chain of sanity checks; registers the
// winning reason code.
// -----------------------------------------------------------------------------
module phaf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	phaf_hdr_if.sink             hdr,
	input  phaf_pkg::cfg_t       cfg,
	input  logic                 q_ready,
	output phaf_pkg::verdict_t   verdict
);

	logic               valid_s1;
	phaf_pkg::reason_t  reason_s1;
	phaf_pkg::reason_t  reason_d;

	logic        src_nz;
	logic        icmp_ok;
	logic [7:0]  fl;
	logic [7:0]  octet;

	always_comb begin
		src_nz = (hdr.source_address != 32'd0);
		fl     = hdr.tcp_flag_bits;
		octet  = hdr.source_address[31:24];

		icmp_ok = ((hdr.icmp_kind == phaf_pkg::ICMP_ECHO_REPLY) && (hdr.icmp_subcode == 8'd0))
			|| ((hdr.icmp_kind == phaf_pkg::ICMP_ECHO_REQ) && (hdr.icmp_subcode == 8'd0))
			|| ((hdr.icmp_kind == phaf_pkg::ICMP_UNREACH)
				&& (hdr.icmp_subcode <= phaf_pkg::ICMP_UNREACH_MAX_CODE))
			|| ((hdr.icmp_kind == phaf_pkg::ICMP_TIME_EXC)
				&& (hdr.icmp_subcode <= phaf_pkg::ICMP_TIME_EXC_MAX_CODE));

		// first check that fires wins
		reason_d = phaf_pkg::RSN_NONE;
		if (src_nz && (hdr.source_address == hdr.dest_address)) begin
			reason_d = phaf_pkg::RSN_LAND;
		end else if ((hdr.time_to_live != 8'd0) && (hdr.time_to_live < cfg.min_ttl)) begin
			reason_d = phaf_pkg::RSN_TTL;
		end else if (src_nz && (hdr.source_address != cfg.local_address)
				&& ((octet == 8'd0) || (octet == phaf_pkg::OCTET_MCAST)
				|| (octet == phaf_pkg::OCTET_RESERVED))) begin
			reason_d = phaf_pkg::RSN_BOGON;
		end else if (hdr.fragmented) begin
			reason_d = phaf_pkg::RSN_FRAG;
		end else if ((hdr.protocol == phaf_pkg::PROTO_ICMP) && !icmp_ok) begin
			reason_d = phaf_pkg::RSN_ICMP;
		end else if ((hdr.protocol == phaf_pkg::PROTO_TCP) && (fl == 8'd0)) begin
			reason_d = phaf_pkg::RSN_NULL;
		end else if ((hdr.protocol == phaf_pkg::PROTO_TCP) && fl[phaf_pkg::FLAG_FIN]
				&& !fl[phaf_pkg::FLAG_ACK]) begin
			reason_d = phaf_pkg::RSN_FIN;
		end else if ((hdr.protocol == phaf_pkg::PROTO_TCP) && fl[phaf_pkg::FLAG_FIN]
				&& fl[phaf_pkg::FLAG_PSH] && fl[phaf_pkg::FLAG_URG]) begin
			reason_d = phaf_pkg::RSN_XMAS;
		end else if ((hdr.protocol == phaf_pkg::PROTO_TCP) && fl[phaf_pkg::FLAG_SYN]
				&& fl[phaf_pkg::FLAG_FIN]) begin
			reason_d = phaf_pkg::RSN_SYNFIN;
		end else if ((hdr.protocol == phaf_pkg::PROTO_TCP) && fl[phaf_pkg::FLAG_SYN]
				&& fl[phaf_pkg::FLAG_RST]) begin
			reason_d = phaf_pkg::RSN_SYNRST;
		end else if ((hdr.protocol == phaf_pkg::PROTO_TCP) && fl[phaf_pkg::FLAG_SYN]
				&& (fl[phaf_pkg::FLAG_PSH] || fl[phaf_pkg::FLAG_URG])) begin
			reason_d = phaf_pkg::RSN_SYNFLAGS;
		end else if ((hdr.protocol == phaf_pkg::PROTO_TCP) && fl[phaf_pkg::FLAG_SYN]
				&& (hdr.payload_length != 16'd0)) begin
			reason_d = phaf_pkg::RSN_SYNDATA;
		end else if (((hdr.protocol == phaf_pkg::PROTO_TCP)
				|| (hdr.protocol == phaf_pkg::PROTO_UDP))
				&& ((hdr.source_port == 16'd0) || (hdr.dest_port == 16'd0))) begin
			reason_d = phaf_pkg::RSN_PORT0;
		end else if ((hdr.protocol == phaf_pkg::PROTO_UDP)
				&& (hdr.dest_port == phaf_pkg::DNS_PORT)
				&& (hdr.packet_size > cfg.dns_size_limit)) begin
			reason_d = phaf_pkg::RSN_DNS;
		end
	end

	assign hdr.ready = !valid_s1 || q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr.ready) begin
			valid_s1 <= hdr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr.valid && hdr.ready) begin
			reason_s1 <= reason_d;
		end
	end

	assign verdict.valid  = valid_s1;
	assign verdict.reason = reason_s1;

endmodule

// File: sv/phaf_queue.sv
// -----------------------------------------------------------------------------
// phaf_queue
// Short FIFO of reason codes between the classifier and the counter stage.
// -----------------------------------------------------------------------------
module phaf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  phaf_pkg::verdict_t   push_in,
	output logic                 push_ready,
	output phaf_pkg::verdict_t   head,
	input  logic                 pop
);

	localparam int PTR_W = $clog2(phaf_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(phaf_pkg::QUEUE_DEPTH + 1);

	phaf_pkg::reason_t  slot_q [phaf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;

	assign push_ready  = (count_q != CNT_W'(phaf_pkg::QUEUE_DEPTH));
	assign push        = push_in.valid && push_ready;
	assign head.valid  = (count_q != '0);
	assign head.reason = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(phaf_pkg::QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(phaf_pkg::QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_in.reason;
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("queue popped while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(phaf_pkg::QUEUE_DEPTH))
		else $error("queue count over depth");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue count did not follow push");
`endif

endmodule

// File: sv/phaf_back.sv
// -----------------------------------------------------------------------------
// phaf_back
// Hit counters per reason with saturating increment, and the verdict output
// register.
// -----------------------------------------------------------------------------
module phaf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  phaf_pkg::verdict_t   head,
	output logic                 pop,
	phaf_res_if.source           res
);

	logic [31:0]        cnt_q [phaf_pkg::NUM_REASONS];
	logic               out_valid_q;
	logic               blocked_q;
	phaf_pkg::reason_t  reason_q;
	logic [31:0]        hits_q;

	logic               hit;
	logic [3:0]         idx;
	logic [31:0]        cur;
	logic [31:0]        nxt;

	assign pop = head.valid && (!out_valid_q || res.ready);
	assign hit = (head.reason != phaf_pkg::RSN_NONE);

	always_comb begin
		idx = hit ? (4'(head.reason) - 4'd1) : 4'd0;
		cur = cnt_q[idx];
		// saturate at all ones
		nxt = (cur == '1) ? cur : cur + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int i = 0; i < phaf_pkg::NUM_REASONS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (hit) begin
					cnt_q[idx] <= nxt;
				end
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			blocked_q <= hit;
			reason_q  <= head.reason;
			hits_q    <= hit ? nxt : 32'd0;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.blocked     = blocked_q;
	assign res.reason      = 4'(reason_q);
	assign res.reason_hits = hits_q;

`ifndef SYNTHESIS
	a_blocked_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.blocked == (reason_q != phaf_pkg::RSN_NONE)))
		else $error("blocked flag disagrees with reason");

	a_pass_zero_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.blocked) |-> (res.reason_hits == 32'd0))
		else $error("passed verdict carries hits");

	a_block_nonzero_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.blocked) |-> (res.reason_hits != 32'd0))
		else $error("blocked verdict with zero hit count");
`endif

endmodule

// File: sv/packet_header_anomaly_filter.sv
// -----------------------------------------------------------------------------
// packet_header_anomaly_filter
// Inline sanity filter for parsed IPv4 headers with per-reason hit counters.
// -----------------------------------------------------------------------------
// Takes one header beat per clock while the verdict side is ready and returns
// one verdict beat per header, in order. A verdict passes the classifier
// register, the two-entry queue and the output register, where the reason's
// 32-bit counter is read, bumped and written back in the same cycle, so
// back-to-back hits on one reason do not stall. Sustained rate is one header
// per cycle while the verdict side is ready. Counters clear at reset and
// saturate. Registers sit at byte addresses 0 (local_address), 4 (min_ttl)
// and 8 (dns_size_limit); write them only while no header is in flight.
// -----------------------------------------------------------------------------
module packet_header_anomaly_filter (
	input  logic         clk,
	input  logic         arst_n,
	phaf_hdr_if.sink     hdr,
	phaf_res_if.source   res,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	phaf_pkg::cfg_t      cfg_q;
	phaf_pkg::verdict_t  front_verdict;
	phaf_pkg::verdict_t  q_head;
	logic                q_ready;
	logic                q_pop;
	logic [1:0]          reg_idx;
	logic                wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_address  <= phaf_pkg::RST_LOCAL_ADDR;
			cfg_q.min_ttl        <= phaf_pkg::RST_MIN_TTL;
			cfg_q.dns_size_limit <= phaf_pkg::RST_DNS_LIMIT;
		end else if (wr_en) begin
			unique case (reg_idx)
				phaf_pkg::REG_LOCAL_ADDR: cfg_q.local_address  <= pwdata;
				phaf_pkg::REG_MIN_TTL:    cfg_q.min_ttl        <= pwdata[7:0];
				phaf_pkg::REG_DNS_LIMIT:  cfg_q.dns_size_limit <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			phaf_pkg::REG_LOCAL_ADDR: prdata = cfg_q.local_address;
			phaf_pkg::REG_MIN_TTL:    prdata = {24'd0, cfg_q.min_ttl};
			phaf_pkg::REG_DNS_LIMIT:  prdata = {16'd0, cfg_q.dns_size_limit};
			default:                  prdata = 32'd0;
		endcase
	end

	phaf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.hdr     (hdr),
		.cfg     (cfg_q),
		.q_ready (q_ready),
		.verdict (front_verdict)
	);

	phaf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_in    (front_verdict),
		.push_ready (q_ready),
		.head       (q_head),
		.pop        (q_pop)
	);

	phaf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.pop    (q_pop),
		.res    (res)
	);

endmodule
